/* hw/rtl/swrf_pkg.sv */
// Shared constants, types and register codes for the sliding window rank filter.
package swrf_pkg;

    localparam int WINDOW      = 64;
    localparam int SAMPLE_BITS = 16;

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int LEN_W  = $clog2(WINDOW + 1);
    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CFG_W  = LEN_W;
    localparam int CIDX_W = 2;

    localparam logic [LEN_W-1:0] LEN_RESET  = LEN_W'(WINDOW);
    localparam logic [IDX_W-1:0] RANK_RESET = IDX_W'(WINDOW / 2 - 1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [IDX_W-1:0]              t_slot;

    typedef enum logic [CIDX_W-1:0] {
        CFG_WINDOW_LEN = 2'd0,
        CFG_RANK_ORDER = 2'd1
    } t_cfg_index;

    // Neighborhood view of one cell of the sorted chain.
    typedef struct packed {
        logic active;    // cell lies inside the configured window
        logic first;     // cell at the low end of the chain
        logic le_left;   // left neighbor stays and is <= the new sample
        logic le_right;  // right neighbor stays and is <= the new sample
        logic del_left;  // removed entry sits at or left of the left neighbor
        logic del_self;  // removed entry sits at or left of this cell
    } t_cell_ctl;

endpackage

/* hw/rtl/swrf_cell.sv */
// One cell of the sorted chain: holds a window value and its slot tag.
module swrf_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic                  i_shift,
    input  swrf_pkg::t_slot       i_home,
    input  swrf_pkg::t_sample     i_sample,
    input  swrf_pkg::t_slot       i_oldest,
    input  swrf_pkg::t_sample     i_left_value,
    input  swrf_pkg::t_slot       i_left_slot,
    input  swrf_pkg::t_sample     i_right_value,
    input  swrf_pkg::t_slot       i_right_slot,
    input  swrf_pkg::t_cell_ctl   i_ctl,
    output swrf_pkg::t_sample     o_value,
    output swrf_pkg::t_slot       o_slot,
    output logic                  o_le,
    output logic                  o_del
);

    swrf_pkg::t_sample r_value, n_value;
    swrf_pkg::t_slot   r_slot, n_slot;
    logic              w_before_del_self;
    logic              w_before_del_left;
    logic              w_ce_self;
    logic              w_ce_left;

    assign o_value = r_value;
    assign o_slot  = r_slot;
    assign o_del   = i_ctl.active && (r_slot == i_oldest);
    assign o_le    = i_ctl.active && !o_del && (r_value <= i_sample);

    // Compacted list after removal: entries right of the removed one move left by one.
    assign w_before_del_self = !i_ctl.del_self;
    assign w_before_del_left = !i_ctl.del_left;
    assign w_ce_self = w_before_del_self ? o_le : i_ctl.le_right;
    assign w_ce_left = i_ctl.first ? 1'b1 : (w_before_del_left ? i_ctl.le_left : o_le);

    always_comb begin
        n_value = r_value;
        n_slot  = r_slot;
        if (i_shift && i_ctl.active) begin
            if (w_ce_self) begin
                n_value = w_before_del_self ? r_value : i_right_value;
                n_slot  = w_before_del_self ? r_slot  : i_right_slot;
            end else if (w_ce_left) begin
                n_value = i_sample;
                n_slot  = i_oldest;
            end else begin
                n_value = w_before_del_left ? i_left_value : r_value;
                n_slot  = w_before_del_left ? i_left_slot  : r_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_value <= '0;
            r_slot  <= i_home;
        end else begin
            r_value <= n_value;
            r_slot  <= n_slot;
        end
    end

endmodule

/* hw/rtl/sliding_window_rank_filter.sv */
// Top level of the sliding window rank filter: cell chain, window control and output register.
//
// Each request carries one signed sample that replaces the oldest of the last window_len
// samples; the block answers with the rank_order-th smallest value of the window (0 is the
// minimum). The window is kept as a sorted row of WINDOW cells; per request the entries
// between the removed and the new place shift by one at once. The cell row updates at the edge
// that takes a request; the rank select then reads the cell row and loads the output register
// as soon as that register is free. While the output side is ready a request is taken every
// clock; when a result sits in a stalled output register and the next request waits in the cell
// row for its rank select, further requests are held off until the output register frees up.
// The window is all zeros after reset and again after any write to the window length or rank
// order; configuration is meant to be written only while no result is outstanding.
module sliding_window_rank_filter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // tdata: [15:0] sample
    input  logic [swrf_pkg::DATA_W-1:0]  i_s_axis_tdata,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // tdata: [15:0] rank_value
    output logic [swrf_pkg::DATA_W-1:0]  o_m_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [swrf_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [swrf_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int W = swrf_pkg::WINDOW;

    logic [swrf_pkg::LEN_W-1:0] r_window_len;
    logic [swrf_pkg::IDX_W-1:0] r_rank_order;
    swrf_pkg::t_slot            r_oldest, n_oldest;
    logic                       r_pend;
    logic                       r_out_valid;
    swrf_pkg::t_sample          r_out_value;

    logic                       w_in_acc;
    logic                       w_cfg_acc;
    logic                       w_out_free;
    logic                       w_clear;
    logic [swrf_pkg::LEN_W-1:0] w_len;
    swrf_pkg::t_slot            w_slot;
    logic [swrf_pkg::LEN_W-1:0] w_slot_inc;
    logic [swrf_pkg::LEN_W-1:0] w_rank_wide;
    swrf_pkg::t_slot            w_rank;
    swrf_pkg::t_sample          w_sample;

    swrf_pkg::t_sample          w_value [W];
    swrf_pkg::t_slot            w_tag   [W];
    logic [W-1:0]               w_le;
    logic [W-1:0]               w_del;
    logic [W-1:0]               w_pre;

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = i_rst_n && (!r_pend || w_out_free);
    assign o_cfg_ready     = i_rst_n && !r_pend;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cfg_acc       = i_cfg_valid && o_cfg_ready;
    assign w_clear         = w_cfg_acc && ((i_cfg_index == swrf_pkg::CFG_WINDOW_LEN)
                                        || (i_cfg_index == swrf_pkg::CFG_RANK_ORDER));
    assign w_sample        = swrf_pkg::t_sample'(i_s_axis_tdata[swrf_pkg::SAMPLE_BITS-1:0]);

    always_comb begin
        if (r_window_len == '0) begin
            w_len = swrf_pkg::LEN_W'(1);
        end else if (r_window_len > swrf_pkg::LEN_W'(W)) begin
            w_len = swrf_pkg::LEN_W'(W);
        end else begin
            w_len = r_window_len;
        end
    end

    assign w_slot     = ({1'b0, r_oldest} >= w_len) ? '0 : r_oldest;
    assign w_slot_inc = {1'b0, w_slot} + swrf_pkg::LEN_W'(1);
    assign n_oldest   = (w_slot_inc >= w_len) ? '0 : w_slot_inc[swrf_pkg::IDX_W-1:0];

    assign w_rank_wide = ({1'b0, r_rank_order} >= w_len) ? (w_len - swrf_pkg::LEN_W'(1))
                                                         : {1'b0, r_rank_order};
    assign w_rank      = w_rank_wide[swrf_pkg::IDX_W-1:0];

    for (genvar k = 0; k < W; k++) begin : g_cell
        swrf_pkg::t_cell_ctl w_ctl;
        swrf_pkg::t_sample   w_lv, w_rv;
        swrf_pkg::t_slot     w_ls, w_rs;

        assign w_pre[k]       = |w_del[k:0];
        assign w_ctl.active   = swrf_pkg::LEN_W'(k) < w_len;
        assign w_ctl.first    = (k == 0);
        assign w_ctl.del_self = w_pre[k];

        if (k == 0) begin : g_lo
            assign w_lv = '0;
            assign w_ls = '0;
            assign w_ctl.le_left  = 1'b0;
            assign w_ctl.del_left = 1'b0;
        end else begin : g_lo
            assign w_lv = w_value[k-1];
            assign w_ls = w_tag[k-1];
            assign w_ctl.le_left  = w_le[k-1];
            assign w_ctl.del_left = w_pre[k-1];
        end

        if (k == W - 1) begin : g_hi
            assign w_rv = '0;
            assign w_rs = '0;
            assign w_ctl.le_right = 1'b0;
        end else begin : g_hi
            assign w_rv = w_value[k+1];
            assign w_rs = w_tag[k+1];
            assign w_ctl.le_right = w_le[k+1];
        end

        swrf_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_clear       (w_clear),
            .i_shift       (w_in_acc),
            .i_home        (swrf_pkg::IDX_W'(k)),
            .i_sample      (w_sample),
            .i_oldest      (w_slot),
            .i_left_value  (w_lv),
            .i_left_slot   (w_ls),
            .i_right_value (w_rv),
            .i_right_slot  (w_rs),
            .i_ctl         (w_ctl),
            .o_value       (w_value[k]),
            .o_slot        (w_tag[k]),
            .o_le          (w_le[k]),
            .o_del         (w_del[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= swrf_pkg::LEN_RESET;
            r_rank_order <= swrf_pkg::RANK_RESET;
            r_oldest     <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_cfg_acc && (i_cfg_index == swrf_pkg::CFG_WINDOW_LEN)) begin
                r_window_len <= i_cfg_data;
            end
            if (w_cfg_acc && (i_cfg_index == swrf_pkg::CFG_RANK_ORDER)) begin
                r_rank_order <= i_cfg_data[swrf_pkg::IDX_W-1:0];
            end
            if (w_clear) begin
                r_oldest <= '0;
            end else if (w_in_acc) begin
                r_oldest <= n_oldest;
            end
            // The pending result is read from the cell row before it shifts again.
            if (r_pend && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_acc) begin
                r_pend <= 1'b1;
            end else if (w_out_free) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && w_out_free) begin
            r_out_value <= w_value[w_rank];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = swrf_pkg::DATA_W'($unsigned(r_out_value));

endmodule

/* hw/rtl/swrf_checker.sv */
// Port-level checker for the sliding window rank filter, bound to the top level.
module swrf_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    input  logic                         o_s_axis_tready,
    input  logic [swrf_pkg::DATA_W-1:0]  o_m_axis_tdata,
    input  logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    input  logic                         o_cfg_ready
);

    // A stalled result keeps its data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // Every accepted request is followed by a valid result at the output.
    a_result_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> ##1 o_m_axis_tvalid)
        else $error("result missing after request");

    // Configuration is refused while a request still waits for its rank select.
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_cfg_ready)
        else $error("configuration open with a request in flight");

endmodule

bind sliding_window_rank_filter swrf_checker u_swrf_checker (.*);

/* dv/tb_top.sv */
// Self-checking testbench for the sliding window rank filter with a built-in rank predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int TARGET_ITEMS  = 1300;
    localparam int MAX_REPORTS   = 10;

    // Indexes outside the register map; writes to them must leave everything untouched.
    localparam logic [swrf_pkg::CIDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [swrf_pkg::CIDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum int {VAL_FULL, VAL_NARROW, VAL_EXTREME, VAL_RAMP} t_val_mode;
    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} t_stall_mode;

    logic                          i_clk     = 1'b0;
    logic                          i_rst_n   = 1'b0;
    logic [swrf_pkg::DATA_W-1:0]   s_tdata   = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [swrf_pkg::DATA_W-1:0]   m_tdata;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [swrf_pkg::CIDX_W-1:0]   cfg_index = '0;
    logic [swrf_pkg::CFG_W-1:0]    cfg_data  = '0;

    // Predictor state: the window contents and the active register values.
    swrf_pkg::t_sample   win_vals [swrf_pkg::WINDOW];
    int                  oldest_slot;
    logic [6:0]          len_reg;
    logic [5:0]          rank_reg;
    swrf_pkg::t_sample   expected_ranks [$];

    int                  err_count    = 0;
    int                  samples_sent = 0;
    int                  cycle_count  = 0;
    int                  burst_left   = 0;
    int                  gap_max      = 0;
    int                  stall_phase  = 0;
    t_stall_mode         stall_mode   = STALL_NONE;
    swrf_pkg::t_sample   ramp_val     = '0;
    swrf_pkg::t_sample   want;

    sliding_window_rank_filter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Output back-pressure, driven from its own pattern independent of the sender.
    always @(negedge i_clk) begin
        stall_phase++;
        case (stall_mode)
            STALL_NONE:     m_tready <= 1'b1;
            STALL_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: m_tready <= ((stall_phase % 7) < 4);
            default:        m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_ranks.size() == 0) begin
                if (err_count < MAX_REPORTS)
                    $display("mismatch: result %0d with nothing pending",
                             $signed(m_tdata[swrf_pkg::SAMPLE_BITS-1:0]));
                err_count++;
            end else begin
                want = expected_ranks.pop_front();
                if (m_tdata !== swrf_pkg::DATA_W'($unsigned(want))) begin
                    if (err_count < MAX_REPORTS)
                        $display("mismatch: rank_value expected %0d got %0d (raw %h)",
                                 want, $signed(m_tdata[swrf_pkg::SAMPLE_BITS-1:0]), m_tdata);
                    err_count++;
                end
            end
        end
    end

    function automatic int active_len();
        if (len_reg == 0) return 1;
        if (len_reg > swrf_pkg::WINDOW) return swrf_pkg::WINDOW;
        return int'(len_reg);
    endfunction

    function automatic void clear_window();
        foreach (win_vals[k]) win_vals[k] = '0;
        oldest_slot = 0;
    endfunction

    // Writes the sample into the oldest slot and returns the value at the active rank.
    function automatic swrf_pkg::t_sample filter_sample(input swrf_pkg::t_sample s);
        int n;
        int r;
        int slot;
        int lt;
        int le;
        n    = active_len();
        r    = (int'(rank_reg) >= n) ? n - 1 : int'(rank_reg);
        slot = (oldest_slot >= n) ? 0 : oldest_slot;
        win_vals[slot] = s;
        oldest_slot = (slot + 1 >= n) ? 0 : slot + 1;
        for (int i = 0; i < n; i++) begin
            lt = 0;
            le = 0;
            for (int j = 0; j < n; j++) begin
                if (win_vals[j] < win_vals[i]) lt++;
                if (win_vals[j] <= win_vals[i]) le++;
            end
            if (lt <= r && r < le) return win_vals[i];
        end
        return '0;
    endfunction

    function automatic swrf_pkg::t_sample make_sample(input t_val_mode m);
        case (m)
            VAL_FULL:   return swrf_pkg::t_sample'($urandom);
            VAL_NARROW: return swrf_pkg::t_sample'(int'($urandom_range(0, 8)) - 4);
            VAL_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return swrf_pkg::t_sample'(-32768);
                    1:       return swrf_pkg::t_sample'(32767);
                    2:       return swrf_pkg::t_sample'(-1);
                    3:       return swrf_pkg::t_sample'(1);
                    default: return '0;
                endcase
            end
            default: begin
                ramp_val = ramp_val + swrf_pkg::t_sample'(int'($urandom_range(0, 6)) - 2);
                return ramp_val;
            end
        endcase
    endfunction

    task automatic push_sample(input swrf_pkg::t_sample s);
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= swrf_pkg::DATA_W'($unsigned(s));
        do @(posedge i_clk); while (!s_tready);
        expected_ranks.push_back(filter_sample(s));
        samples_sent++;
    endtask

    task automatic hold_off(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_run(input int count, input t_val_mode m);
        for (int i = 0; i < count; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                if (gap_max > 0) hold_off($urandom_range(0, gap_max));
            end
            burst_left--;
            push_sample(make_sample(m));
        end
    endtask

    task automatic wait_results_done();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (expected_ranks.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [swrf_pkg::CIDX_W-1:0] idx,
                             input logic [swrf_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        if (idx == swrf_pkg::CFG_WINDOW_LEN) begin
            len_reg = val;
            clear_window();
        end else if (idx == swrf_pkg::CFG_RANK_ORDER) begin
            rank_reg = val[5:0];
            clear_window();
        end
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int len, input int rank);
        wait_results_done();
        write_reg(swrf_pkg::CFG_WINDOW_LEN, swrf_pkg::CFG_W'(len));
        write_reg(swrf_pkg::CFG_RANK_ORDER, swrf_pkg::CFG_W'(rank));
    endtask

    // Default window of 64 zeros with the median rank: every answer stays zero.
    task automatic test_reset_state();
        push_sample(swrf_pkg::t_sample'(32767));
        push_sample(swrf_pkg::t_sample'(-32768));
        push_sample(swrf_pkg::t_sample'(-1));
        push_sample(swrf_pkg::t_sample'(1));
    endtask

    task automatic test_window_edges();
        configure(1, 0);
        push_sample(swrf_pkg::t_sample'(-32768));
        push_sample(swrf_pkg::t_sample'(32767));
        push_sample('0);
        // A length of zero behaves as a single-sample window.
        configure(0, 5);
        push_sample(swrf_pkg::t_sample'(123));
        push_sample(swrf_pkg::t_sample'(-7));
        configure(3, 2);
        push_sample(swrf_pkg::t_sample'(5));
        push_sample(swrf_pkg::t_sample'(-32768));
        push_sample(swrf_pkg::t_sample'(32767));
        push_sample(swrf_pkg::t_sample'(-1));
    endtask

    task automatic test_rank_clamp();
        configure(4, 63);
        push_sample(swrf_pkg::t_sample'(-32768));
        push_sample(swrf_pkg::t_sample'(-2));
        push_sample(swrf_pkg::t_sample'(32767));
        push_sample(swrf_pkg::t_sample'(-32768));
        // Oversized length saturates at the full window; bit 6 of the rank is dropped.
        configure(127, 7'h40);
        push_sample(swrf_pkg::t_sample'(-5));
        push_sample(swrf_pkg::t_sample'(32767));
        push_sample(swrf_pkg::t_sample'(-32768));
        push_sample(swrf_pkg::t_sample'(9));
    endtask

    task automatic test_unknown_index();
        configure(5, 2);
        push_sample(swrf_pkg::t_sample'(300));
        push_sample(swrf_pkg::t_sample'(-300));
        push_sample(swrf_pkg::t_sample'(7));
        wait_results_done();
        write_reg(CFG_SPARE_2, '0);
        write_reg(CFG_SPARE_3, 7'h7F);
        push_sample(swrf_pkg::t_sample'(1000));
        push_sample(swrf_pkg::t_sample'(-1000));
    endtask

    // The sender stops mid-stream until the output side has caught up completely.
    task automatic test_drain_pause();
        configure(16, 8);
        stall_mode = STALL_PERIODIC;
        gap_max    = 3;
        send_run(40, VAL_FULL);
        wait_results_done();
        send_run(40, VAL_NARROW);
    endtask

    task automatic test_random_traffic();
        int len;
        int eff;
        int rank;
        int count;
        t_val_mode m;
        while (samples_sent < TARGET_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       len = $urandom_range(1, 3);
                1:       len = 0;
                2:       len = $urandom_range(swrf_pkg::WINDOW + 1, 127);
                3:       len = swrf_pkg::WINDOW;
                default: len = $urandom_range(2, swrf_pkg::WINDOW);
            endcase
            eff = (len == 0) ? 1 : (len > swrf_pkg::WINDOW) ? swrf_pkg::WINDOW : len;
            case ($urandom_range(0, 5))
                0:       rank = 0;
                1:       rank = $urandom_range(64, 127);
                2:       rank = 63;
                default: rank = $urandom_range(0, eff - 1);
            endcase
            wait_results_done();
            write_reg(swrf_pkg::CFG_WINDOW_LEN, swrf_pkg::CFG_W'(len));
            if ($urandom_range(0, 3) != 0)
                write_reg(swrf_pkg::CFG_RANK_ORDER, swrf_pkg::CFG_W'(rank));

            stall_mode = t_stall_mode'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0:       gap_max = 0;
                1:       gap_max = 1;
                2:       gap_max = 3;
                default: gap_max = 6;
            endcase
            m     = t_val_mode'($urandom_range(0, 3));
            count = $urandom_range(30, 140);
            if ($urandom_range(0, 3) == 0) begin
                send_run(count / 2, m);
                wait_results_done();
                send_run(count - count / 2, m);
            end else begin
                send_run(count, m);
            end
        end
    endtask

    initial begin
        len_reg  = swrf_pkg::LEN_RESET;
        rank_reg = swrf_pkg::RANK_RESET;
        clear_window();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_window_edges();
        test_rank_clamp();
        test_unknown_index();
        test_drain_pause();
        test_random_traffic();

        wait_results_done();
        stall_mode = STALL_NONE;
        repeat (8) @(posedge i_clk);
        if (err_count == 0 && expected_ranks.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/swrf_pkg.sv
hw/rtl/swrf_cell.sv
hw/rtl/sliding_window_rank_filter.sv
hw/rtl/swrf_checker.sv
dv/tb_top.sv
